/* design/pcfg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfg_pkg
// Shared constants and controller/datapath interface types for the
// multichannel pulse counter with frequency gate.
// ----------------------------------------------------------------------------
package pcfg_pkg;

	// Field widths fixed by the interface
	localparam int OP_W    = 2;
	localparam int MASK_W  = 16;
	localparam int IDX_W   = 4;
	localparam int KIND_W  = 2;
	localparam int VALUE_W = 32;
	localparam int GCNT_W  = 16;
	localparam int TIMER_W = 16;

	// Defaults for the top-level parameters
	localparam int CHANNELS_DEF         = 16;
	localparam int CLEARED_CHANNELS_DEF = 14;

	// Most gate results one close reports, and the channels a 4-bit index reaches
	localparam int MAX_RESULTS = 16;
	localparam int CHAN_LIMIT  = 16;

	// Gate length after reset
	localparam logic [TIMER_W-1:0] GATE_TICKS_RST = 16'd1000;

	// Operation codes
	localparam logic [OP_W-1:0] OP_EDGE = 2'd0;
	localparam logic [OP_W-1:0] OP_TICK = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_EDGE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_GATE  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_TOTAL = 2'd3;

	// Commands from controller to datapath
	typedef struct packed {
		logic             take;        // input transfer this cycle
		logic             emit_gate;   // load one gate result
		logic             gate_last;   // that result closes the sequence
		logic             clear_gate;  // clear the low gate counts
		logic [IDX_W-1:0] gate_idx;    // channel of the gate result
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic out_valid;   // result register occupied
		logic gate_match;  // next tick closes the gate
	} stat_t;

endpackage

/* design/pcfg_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfg_ctrl
// Controller: takes input items and sequences the gate-close results,
// one channel per free slot of the result register.
// ----------------------------------------------------------------------------
module pcfg_ctrl import pcfg_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [OP_W-1:0] operation,
	input  logic            out_ready,
	input  stat_t           stat,
	output cmd_t            cmd
);

	localparam int NRES = (CHANNELS < MAX_RESULTS) ? CHANNELS : MAX_RESULTS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NRES - 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_GATE = 2'b10
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_free;
	logic             go_gate;

	// Result register can take a new result this cycle
	assign out_free = !stat.out_valid || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;

	// Build commands
	always_comb begin
		cmd            = '0;
		cmd.take       = in_valid && in_ready;
		cmd.gate_idx   = idx_q;
		cmd.emit_gate  = (state_q == ST_GATE) && out_free;
		cmd.gate_last  = (idx_q == LAST_IDX);
		cmd.clear_gate = cmd.emit_gate && cmd.gate_last;
	end

	assign go_gate = cmd.take && (operation == OP_TICK) && stat.gate_match;

	// Advance state and gate index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (go_gate) begin
						state_q <= ST_GATE;
						idx_q   <= '0;
					end
				end
				ST_GATE: begin
					if (cmd.emit_gate) begin
						if (cmd.gate_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// No input transfer while gate results are going out
	a_no_take_in_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GATE) |-> !cmd.take)
		else $error("input transfer during gate sequence");

	// Counts are cleared only with the final gate result
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_gate |-> (cmd.emit_gate && idx_q == LAST_IDX))
		else $error("gate counts cleared early");

	// Final gate result returns the controller to idle
	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_gate |=> (state_q == ST_IDLE))
		else $error("controller stuck after gate sequence");

	// A gate close starts from channel zero
	a_gate_start: assert property (@(posedge clk) disable iff (!arst_n)
		go_gate |=> (state_q == ST_GATE && idx_q == '0))
		else $error("gate sequence not started at channel zero");

endmodule

/* design/pcfg_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfg_dp
// Datapath: per-channel totals and gate counts, gate timer, gate setting
// and the result register.
// ----------------------------------------------------------------------------
module pcfg_dp import pcfg_pkg::*; #(
	parameter int CHANNELS         = CHANNELS_DEF,
	parameter int CLEARED_CHANNELS = CLEARED_CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               gate_ticks_we,
	input  logic [TIMER_W-1:0] gate_ticks_wdata,
	input  logic [OP_W-1:0]    operation,
	input  logic [MASK_W-1:0]  edge_mask,
	input  logic [IDX_W-1:0]   read_channel,
	input  logic               out_ready,
	input  cmd_t               cmd,
	output stat_t              stat,
	output logic               out_valid,
	output logic [KIND_W-1:0]  result_kind,
	output logic [IDX_W-1:0]   channel,
	output logic [VALUE_W-1:0] value,
	output logic               last
);

	localparam int NRES = (CHANNELS < MAX_RESULTS) ? CHANNELS : MAX_RESULTS;

	logic [VALUE_W-1:0]         total_q [CHANNELS];
	logic [GCNT_W-1:0]          gcount_q [CHANNELS];
	logic [TIMER_W-1:0]         timer_q;
	logic [TIMER_W-1:0]         gate_ticks_q;
	logic [TIMER_W-1:0]         timer_nxt;
	logic [CHANNELS+MASK_W-1:0] mask_ext;
	logic [VALUE_W-1:0]         rd_total;
	logic [GCNT_W-1:0]          rd_gcount;
	logic                       edge_take;
	logic                       tick_take;
	logic                       load;

	logic                       out_valid_q;
	logic [KIND_W-1:0]          kind_q;
	logic [IDX_W-1:0]           chan_q;
	logic [VALUE_W-1:0]         value_q;
	logic                       last_q;

	assign timer_nxt  = timer_q + 1'b1;
	assign mask_ext   = {{CHANNELS{1'b0}}, edge_mask};
	assign edge_take  = cmd.take && (operation == OP_EDGE);
	assign tick_take  = cmd.take && (operation == OP_TICK);

	assign stat.out_valid  = out_valid_q;
	assign stat.gate_match = (timer_nxt == gate_ticks_q);

	// Select the running total for a read; missing channels read zero
	always_comb begin
		rd_total = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (i < CHAN_LIMIT && read_channel == IDX_W'(i)) begin
				rd_total = total_q[i];
			end
		end
	end

	// Select the gate count being reported
	always_comb begin
		rd_gcount = '0;
		for (int i = 0; i < NRES; i++) begin
			if (cmd.gate_idx == IDX_W'(i)) begin
				rd_gcount = gcount_q[i];
			end
		end
	end

	// Count edges per channel; clear the low gate counts after a close
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				total_q[i]  <= '0;
				gcount_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (edge_take && mask_ext[i]) begin
					total_q[i]  <= total_q[i] + 1'b1;
					gcount_q[i] <= gcount_q[i] + 1'b1;
				end else if (cmd.clear_gate && i < CLEARED_CHANNELS) begin
					gcount_q[i] <= '0;
				end
			end
		end
	end

	// Advance gate timer and hold the gate setting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q      <= '0;
			gate_ticks_q <= GATE_TICKS_RST;
		end else begin
			if (gate_ticks_we) begin
				gate_ticks_q <= gate_ticks_wdata;
			end
			if (tick_take) begin
				timer_q <= stat.gate_match ? '0 : timer_nxt;
			end
		end
	end

	// Result register occupancy
	assign load = cmd.emit_gate
		|| (cmd.take && (operation == OP_EDGE || operation == OP_READ))
		|| (tick_take && !stat.gate_match);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.emit_gate) begin
			kind_q  <= KIND_GATE;
			chan_q  <= cmd.gate_idx;
			value_q <= {{(VALUE_W-GCNT_W){1'b0}}, rd_gcount};
			last_q  <= cmd.gate_last;
		end else if (cmd.take) begin
			case (operation)
				OP_EDGE: begin
					kind_q  <= KIND_EDGE;
					chan_q  <= '0;
					value_q <= '0;
					last_q  <= 1'b1;
				end
				OP_TICK: begin
					kind_q  <= KIND_TICK;
					chan_q  <= '0;
					value_q <= '0;
					last_q  <= 1'b1;
				end
				OP_READ: begin
					kind_q  <= KIND_TOTAL;
					chan_q  <= read_channel;
					value_q <= rd_total;
					last_q  <= 1'b1;
				end
				default: begin
					kind_q <= kind_q;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign channel     = chan_q;
	assign value       = value_q;
	assign last        = last_q;

	// A closing tick leaves the timer at zero
	a_timer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_take && stat.gate_match) |=> (timer_q == '0))
		else $error("gate timer not cleared on close");

	// Channel zero is among the cleared gate counts whenever CLEARED_CHANNELS is nonzero
	a_gcount_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_gate |=> (gcount_q[0] == '0))
		else $error("gate count not cleared after close");

	// Gate results never overwrite a result still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !load)
		else $error("result register overwritten");

endmodule

/* design/pulse_counter_frequency_gate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_counter_frequency_gate
// Multichannel pulse counter with a frequency gate: edge items raise
// per-channel totals and gate counts, tick items run the gate timer and a
// gate close reports the gate counts of the first min(CHANNELS, 16) channels.
// ----------------------------------------------------------------------------
//  Channel   Handshake                Payload
//  input     in_valid / in_ready      operation, edge_mask, read_channel
//  result    out_valid / out_ready    result_kind, channel, value, last
//  config    gate_ticks_we            gate_ticks_wdata
//
//  An edge, plain tick or read item is accepted whenever the result register
//  is empty or being emptied in the same cycle.
//  A gate-closing tick emits min(CHANNELS, 16) results, one per cycle through
//  the single result register, and no input is accepted until the last goes.
//  Stalls on out_ready hold the result register and back-pressure the input.
//  Reset clears all counts, the timer and sets the gate to 1000 ticks at
//  once; there is no clearing pass.
// ----------------------------------------------------------------------------
module pulse_counter_frequency_gate import pcfg_pkg::*; #(
	parameter int CHANNELS         = CHANNELS_DEF,
	parameter int CLEARED_CHANNELS = CLEARED_CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               gate_ticks_we,
	input  logic [TIMER_W-1:0] gate_ticks_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [OP_W-1:0]    operation,
	input  logic [MASK_W-1:0]  edge_mask,
	input  logic [IDX_W-1:0]   read_channel,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [KIND_W-1:0]  result_kind,
	output logic [IDX_W-1:0]   channel,
	output logic [VALUE_W-1:0] value,
	output logic               last
);

	cmd_t  cmd;
	stat_t stat;

	// Controller
	pcfg_ctrl #(
		.CHANNELS (CHANNELS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath
	pcfg_dp #(
		.CHANNELS         (CHANNELS),
		.CLEARED_CHANNELS (CLEARED_CHANNELS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.gate_ticks_we    (gate_ticks_we),
		.gate_ticks_wdata (gate_ticks_wdata),
		.operation        (operation),
		.edge_mask        (edge_mask),
		.read_channel     (read_channel),
		.out_ready        (out_ready),
		.cmd              (cmd),
		.stat             (stat),
		.out_valid        (out_valid),
		.result_kind      (result_kind),
		.channel          (channel),
		.value            (value),
		.last             (last)
	);

endmodule
